// File: design/assert_macros.svh
// assertion helpers for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rach_pkg.sv
`timescale 1ns / 1ps
package rach_pkg;
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int LAYER_BITS_DEF    = 16;
  localparam int ID_WIDTH_DEF      = 16;

  localparam int REG_ORIGIN_X = 0;
  localparam int REG_ORIGIN_Y = 1;
  localparam int REG_DIR_X    = 2;
  localparam int REG_DIR_Y    = 3;
  localparam int REG_MAX_DIST = 4;
  localparam int REG_LAYER    = 5;
  localparam int CFG_IDX_W    = 3;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture box request
    logic div_start;  // start division for current slab term
    logic slab_done;  // fold quotient pair of current axis into limits
    logic axis;       // 0 = x, 1 = y
    logic term;       // 0 = min corner, 1 = max corner
    logic mul_start;  // start hit point multiply
    logic mul_axis;
    logic commit;     // update best on hit
    logic clear;      // clear best after report
  } rach_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;       // inactive or masked out
    logic zero_dir;   // direction of selected axis is zero
    logic outside;    // origin outside slab of selected axis
    logic div_busy;
    logic mul_busy;
    logic is_hit;     // candidate closer than best
    logic last;
  } rach_sts_t;
endpackage

// File: design/rach_datapath.sv
`timescale 1ns / 1ps
module rach_datapath #(
  parameter int COORD_WIDTH   = rach_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = rach_pkg::FRACTION_BITS_DEF,
  parameter int LAYER_BITS    = rach_pkg::LAYER_BITS_DEF,
  parameter int ID_WIDTH      = rach_pkg::ID_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rach_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic signed [COORD_WIDTH-1:0] box_min_x,
  input  logic signed [COORD_WIDTH-1:0] box_min_y,
  input  logic signed [COORD_WIDTH-1:0] box_max_x,
  input  logic signed [COORD_WIDTH-1:0] box_max_y,
  input  logic                          active,
  input  logic [LAYER_BITS-1:0]         layers,
  input  logic [ID_WIDTH-1:0]           box_id,
  input  logic                          last,
  input  rach_pkg::rach_cmd_t           cmd,
  output rach_pkg::rach_sts_t           sts,
  output logic                          r_hit,
  output logic [COORD_WIDTH-1:0]        r_distance,
  output logic signed [COORD_WIDTH-1:0] r_point_x,
  output logic signed [COORD_WIDTH-1:0] r_point_y,
  output logic [ID_WIDTH-1:0]           r_hit_id
);
  import rach_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;               // corner minus origin
  localparam int QB  = W + 1 + FRACTION_BITS; // quotient steps
  localparam int CW  = $clog2(QB + 1);
  localparam int TW  = W + 2;               // signed parameter width
  localparam int PW  = 2 * W;               // product width
  localparam int MW  = $clog2(W + 1);
  localparam logic [W-1:0] TLIM = '1;

  // configuration
  logic signed [W-1:0] origin_x, origin_y, dir_x, dir_y;
  logic [W-1:0] max_distance;
  logic [LAYER_BITS-1:0] layer_mask;

  // best
  logic best_valid;
  logic [W-1:0] best_distance;
  logic signed [W-1:0] best_point_x, best_point_y;
  logic [ID_WIDTH-1:0] best_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      dir_x <= W'(1) << FRACTION_BITS;
      dir_y <= '0;
      max_distance <= '1;
      layer_mask <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_W'(REG_ORIGIN_X): origin_x <= cfg_data;
        CFG_IDX_W'(REG_ORIGIN_Y): origin_y <= cfg_data;
        CFG_IDX_W'(REG_DIR_X):    dir_x <= cfg_data;
        CFG_IDX_W'(REG_DIR_Y):    dir_y <= cfg_data;
        CFG_IDX_W'(REG_MAX_DIST): max_distance <= cfg_data;
        CFG_IDX_W'(REG_LAYER):    layer_mask <= LAYER_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // captured box
  logic signed [W-1:0] bx0, by0, bx1, by1;
  logic b_act, b_last;
  logic [LAYER_BITS-1:0] b_layers;
  logic [ID_WIDTH-1:0] b_id;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bx0 <= box_min_x;
      by0 <= box_min_y;
      bx1 <= box_max_x;
      by1 <= box_max_y;
      b_act <= active;
      b_layers <= layers;
      b_id <= box_id;
      b_last <= last;
    end
  end

  // axis selection
  logic signed [W-1:0] a_org, a_dir, a_lo, a_hi, a_corner;
  assign a_org = cmd.axis ? origin_y : origin_x;
  assign a_dir = cmd.axis ? dir_y : dir_x;
  assign a_lo  = cmd.axis ? by0 : bx0;
  assign a_hi  = cmd.axis ? by1 : bx1;
  assign a_corner = cmd.term ? a_hi : a_lo;

  // restoring divider, one quotient bit per cycle
  logic signed [DW-1:0] num_s;
  logic [DW-1:0] d_num;
  logic [W-1:0]  d_den;
  logic [W:0]    d_rem;
  logic [W:0]    d_q;
  logic          d_sat, d_neg, d_busy;
  logic [CW-1:0] d_cnt;
  logic [W:0]    rem_sh, rem_sub;
  logic          d_bit, d_ge;
  logic [W+1:0]  q_sh;

  assign num_s = DW'(a_corner) - DW'(a_org);
  assign d_bit = (d_cnt >= CW'(FRACTION_BITS + 1)) ? d_num[DW-1] : 1'b0;
  assign rem_sh = {d_rem[W-1:0], d_bit};
  assign d_ge = rem_sh >= {1'b0, d_den};
  assign rem_sub = d_ge ? rem_sh - {1'b0, d_den} : rem_sh;
  assign q_sh = {d_q, d_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_busy <= 1'b0;
    end else if (cmd.div_start) begin
      d_busy <= 1'b1;
    end else if (d_busy && d_cnt == CW'(1)) begin
      d_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      d_num <= num_s[DW-1] ? DW'(-num_s) : DW'(num_s);
      d_den <= a_dir[W-1] ? W'(-a_dir) : W'(a_dir);
      d_neg <= num_s[DW-1] ^ a_dir[W-1];
      d_rem <= '0;
      d_q <= '0;
      d_sat <= 1'b0;
      d_cnt <= CW'(QB);
    end else if (d_busy) begin
      if (d_cnt >= CW'(FRACTION_BITS + 1)) d_num <= d_num << 1;
      d_rem <= rem_sub;
      d_cnt <= d_cnt - CW'(1);
      if (!d_sat) begin
        if (q_sh[W+1] || q_sh[W]) d_sat <= 1'b1;
        else d_q <= q_sh[W:0];
      end
    end
  end

  logic signed [TW-1:0] quot;
  logic [W-1:0] qmag;
  assign qmag = d_sat ? TLIM : d_q[W-1:0];
  assign quot = d_neg ? -TW'({2'b00, qmag}) : TW'({2'b00, qmag});

  // slab limits
  logic signed [TW-1:0] t1, tmin, tmax;
  logic signed [TW-1:0] lo_t, hi_t;
  assign lo_t = (t1 > quot) ? quot : t1;
  assign hi_t = (t1 > quot) ? t1 : quot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tmin <= {1'b1, {(TW-1){1'b0}}};
      tmax <= {1'b0, {(TW-1){1'b1}}};
    end else if (cmd.slab_done) begin
      if (lo_t > tmin) tmin <= lo_t;
      if (hi_t < tmax) tmax <= hi_t;
    end
  end

  // first quotient of each axis is parked in t1 when the second division starts
  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.term) t1 <= quot;
  end

  logic signed [TW-1:0] ts;
  logic [W-1:0] t_sel;
  logic cand;
  assign ts = (tmin >= 0) ? tmin : tmax;
  assign t_sel = (ts > TW'({2'b00, TLIM})) ? TLIM : ts[W-1:0];
  assign cand = !(tmax < tmin) && !(tmax < 0);

  // shift-add multiplier, one bit of t per cycle
  logic [W-1:0]  m_a;
  logic [W-1:0]  m_b;
  logic [PW-1:0] m_acc;
  logic [MW-1:0] m_cnt;
  logic          m_busy;
  logic [W-1:0]  t_hold;
  logic signed [W-1:0] px, py;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_busy <= 1'b0;
    end else if (cmd.mul_start) begin
      m_busy <= 1'b1;
    end else if (m_busy && m_cnt == MW'(1)) begin
      m_busy <= 1'b0;
    end
  end

  logic [PW-1:0] m_add;
  assign m_add = m_b[W-1] ? (m_acc << 1) + PW'(m_a) : (m_acc << 1);

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      m_a <= a_dir[W-1] ? W'(-a_dir) : W'(a_dir);
      m_b <= t_sel;
      m_acc <= '0;
      m_cnt <= MW'(W);
      t_hold <= t_sel;
    end else if (m_busy) begin
      m_acc <= m_add;
      m_b <= m_b << 1;
      m_cnt <= m_cnt - MW'(1);
    end
  end

  // saturated origin plus product
  localparam logic [PW-1:0] PLIM = PW'(1) << (W + 1);
  logic [PW-1:0] pm;
  logic signed [W+2:0] s_wide;
  logic signed [W-1:0] s_sat;
  localparam logic signed [W+2:0] SMAX = (W+3)'(TLIM >> 1);
  localparam logic signed [W+2:0] SMIN = -SMAX - (W+3)'(1);
  assign pm = ((m_acc >> FRACTION_BITS) > PLIM) ? PLIM : (m_acc >> FRACTION_BITS);
  assign s_wide = a_dir[W-1] ? (W+3)'(a_org) - (W+3)'(pm[W+1:0])
                             : (W+3)'(a_org) + (W+3)'(pm[W+1:0]);
  assign s_sat = (s_wide > SMAX) ? SMAX[W-1:0] :
                 (s_wide < SMIN) ? SMIN[W-1:0] : s_wide[W-1:0];

  // product becomes visible the cycle after the multiply ends
  logic m_done_d;
  always_ff @(posedge clk) begin
    if (rst) m_done_d <= 1'b0;
    else m_done_d <= m_busy && m_cnt == MW'(1);
    if (m_done_d) begin
      if (cmd.mul_axis) py <= s_sat;
      else px <= s_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      best_valid <= 1'b0;
      best_distance <= (rst) ? TLIM : max_distance;
      best_point_x <= '0;
      best_point_y <= '0;
      best_id <= '0;
    end else if (cmd.commit) begin
      best_valid <= 1'b1;
      best_distance <= t_hold;
      best_point_x <= px;
      best_point_y <= py;
      best_id <= b_id;
    end else if (cfg_we && cfg_index == CFG_IDX_W'(REG_MAX_DIST) && !best_valid) begin
      best_distance <= cfg_data;
    end
  end

  assign sts.skip = !b_act || ((b_layers & layer_mask) == '0);
  assign sts.zero_dir = (a_dir == '0);
  assign sts.outside = (a_org < a_lo) || (a_org > a_hi);
  assign sts.div_busy = d_busy;
  assign sts.mul_busy = m_busy || m_done_d;
  assign sts.is_hit = cand && (t_sel < best_distance);
  assign sts.last = b_last;

  assign r_hit = best_valid;
  assign r_distance = best_distance;
  assign r_point_x = best_point_x;
  assign r_point_y = best_point_y;
  assign r_hit_id = best_id;
endmodule

// File: design/rach_ctrl.sv
`timescale 1ns / 1ps
module rach_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rach_pkg::rach_cmd_t cmd,
  input  rach_pkg::rach_sts_t sts
);
  import rach_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_AXIS, S_DIV_START, S_DIV_WAIT, S_FOLD,
    S_EVAL, S_MUL_START, S_MUL_WAIT, S_COMMIT, S_REPORT
  } state_t;

  state_t state;
  logic axis, term, mul_axis;

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.axis = (state == S_MUL_START || state == S_MUL_WAIT) ? mul_axis : axis;
    cmd.term = term;
    cmd.div_start = (state == S_DIV_START);
    cmd.slab_done = (state == S_FOLD);
    cmd.mul_start = (state == S_MUL_START);
    cmd.mul_axis = mul_axis;
    cmd.commit = (state == S_COMMIT);
    cmd.clear = (state == S_REPORT) && out_ready;
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis <= 1'b0;
      term <= 1'b0;
      mul_axis <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
            axis <= 1'b0;
            term <= 1'b0;
          end
        end
        S_CHECK: begin
          state <= sts.skip ? (sts.last ? S_REPORT : S_IDLE) : S_AXIS;
          if (sts.skip && sts.last) out_valid <= 1'b1;
        end
        S_AXIS: begin
          term <= 1'b0;
          priority if (sts.zero_dir && sts.outside) begin
            state <= sts.last ? S_REPORT : S_IDLE;
            out_valid <= sts.last;
          end else if (sts.zero_dir) begin
            if (axis) state <= S_EVAL;
            else axis <= 1'b1;
          end else begin
            state <= S_DIV_START;
          end
        end
        S_DIV_START: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!sts.div_busy) begin
            if (!term) begin
              term <= 1'b1;
              state <= S_DIV_START;
            end else begin
              state <= S_FOLD;
            end
          end
        end
        S_FOLD: begin
          if (axis) begin
            state <= S_EVAL;
          end else begin
            axis <= 1'b1;
            state <= S_AXIS;
          end
        end
        S_EVAL: begin
          if (sts.is_hit) begin
            mul_axis <= 1'b0;
            state <= S_MUL_START;
          end else begin
            state <= sts.last ? S_REPORT : S_IDLE;
            out_valid <= sts.last;
          end
        end
        S_MUL_START: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (!sts.mul_busy) begin
            if (!mul_axis) begin
              mul_axis <= 1'b1;
              state <= S_MUL_START;
            end else begin
              state <= S_COMMIT;
            end
          end
        end
        S_COMMIT: begin
          state <= sts.last ? S_REPORT : S_IDLE;
          out_valid <= sts.last;
        end
        S_REPORT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/ray_aabb_closest_hit_2d_unit.sv
`timescale 1ns / 1ps
// channel | handshake                  | payload
// box in  | box_valid / box_ready      | box_min_x .. last
// result  | result_valid / result_ready| hit distance point_x point_y hit_id
// config  | cfg_we (no wait)           | cfg_index cfg_data
// a box runs the two slab divisions of each axis with nonzero direction on one shared divider of
// QB = COORD_WIDTH+FRACTION_BITS+1 quotient bits, plus two runs of the shift-add multiplier
// when the box improves the hit
// one box in flight at a time; the result holds until result_ready
// rst is synchronous and restores register defaults and clears the best hit
module ray_aabb_closest_hit_2d_unit #(
  parameter int COORD_WIDTH   = rach_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = rach_pkg::FRACTION_BITS_DEF,
  parameter int LAYER_BITS    = rach_pkg::LAYER_BITS_DEF,
  parameter int ID_WIDTH      = rach_pkg::ID_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rach_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]         cfg_data,
  input  logic                           box_valid,
  output logic                           box_ready,
  input  logic signed [COORD_WIDTH-1:0]  box_min_x,
  input  logic signed [COORD_WIDTH-1:0]  box_min_y,
  input  logic signed [COORD_WIDTH-1:0]  box_max_x,
  input  logic signed [COORD_WIDTH-1:0]  box_max_y,
  input  logic                           active,
  input  logic [LAYER_BITS-1:0]          layers,
  input  logic [ID_WIDTH-1:0]            box_id,
  input  logic                           last,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           hit,
  output logic [COORD_WIDTH-1:0]         distance,
  output logic signed [COORD_WIDTH-1:0]  point_x,
  output logic signed [COORD_WIDTH-1:0]  point_y,
  output logic [ID_WIDTH-1:0]            hit_id
);
  import rach_pkg::*;

  rach_cmd_t cmd;
  rach_sts_t sts;

  rach_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(box_valid), .in_ready(box_ready),
    .out_valid(result_valid), .out_ready(result_ready),
    .cmd, .sts
  );

  rach_datapath #(
    .COORD_WIDTH(COORD_WIDTH), .FRACTION_BITS(FRACTION_BITS),
    .LAYER_BITS(LAYER_BITS), .ID_WIDTH(ID_WIDTH)
  ) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .box_min_x, .box_min_y, .box_max_x, .box_max_y,
    .active, .layers, .box_id, .last,
    .cmd, .sts,
    .r_hit(hit), .r_distance(distance), .r_point_x(point_x),
    .r_point_y(point_y), .r_hit_id(hit_id)
  );
endmodule

// File: design/rach_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rach_checker (
  input logic clk,
  input logic rst,
  input logic box_valid,
  input logic box_ready,
  input logic result_valid,
  input logic result_ready,
  input logic hit,
  input logic [15:0] hit_id
);
  `CHK_IMPLY(a_no_in_during_out, clk, rst, result_valid, !box_ready, "box taken while result pending")
  `CHK_NEXT(a_busy_after_accept, clk, rst, box_valid && box_ready, !box_ready, "ready held after request")
  `CHK_IMPLY(a_miss_id_zero, clk, rst, result_valid && !hit, hit_id == '0, "miss with nonzero id")
  `CHK_NEXT(a_out_holds, clk, rst, result_valid && !result_ready, result_valid, "result dropped")
endmodule

bind ray_aabb_closest_hit_2d_unit rach_checker u_chk (
  .clk, .rst, .box_valid, .box_ready, .result_valid, .result_ready,
  .hit, .hit_id(16'(hit_id))
);
